FILE: hw/rtl/generational_handle_allocator_core_assert.svh
// Assertion macros shared by the handle allocator RTL.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while reset is high.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_CORE_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_CORE_ASSERT_SVH

// The condition holds at every clock edge.
`define GHAC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define GHAC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define GHAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/ghac_pkg.sv
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Request and response payload types, command codes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ghac_pkg;

   // Fixed widths of the port fields.
   localparam int HANDLE_BITS       = 32;
   localparam int GEN_BITS          = 16;
   localparam int LOW_BITS          = 16;
   localparam int PORT_PAYLOAD_BITS = 32;
   localparam int COMMAND_BITS      = 3;

   // Command codes.
   typedef enum logic [COMMAND_BITS-1:0] {
      CMD_ALLOC = 3'd0,
      CMD_GET   = 3'd1,
      CMD_FREE  = 3'd2,
      CMD_VALID = 3'd3,
      CMD_FIND  = 3'd4
   } ghac_cmd_type;

   // One request.
   typedef struct packed {
      logic [COMMAND_BITS-1:0]      command;
      logic [HANDLE_BITS-1:0]       handle_in;
      logic [PORT_PAYLOAD_BITS-1:0] payload_in;
   } ghac_req_type;

   // One response.
   typedef struct packed {
      logic [HANDLE_BITS-1:0]       handle_out;
      logic [PORT_PAYLOAD_BITS-1:0] payload_out;
      logic                         success;
   } ghac_rsp_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ghac_slot_mem.sv
// ----------------------------------------------------------------------------
// Slot memory
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module ghac_slot_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8,
   parameter int WIDTH = 57
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] slot_ram [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ram[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/ghac_engine.sv
// ----------------------------------------------------------------------------
// Handle allocator engine
// Sequencer that clears the slot memory after reset, then runs each request
// as a read and optional write-back of one slot, or as a scan for find.
// ----------------------------------------------------------------------------
`default_nettype none

`include "generational_handle_allocator_core_assert.svh"

module ghac_engine #(
   parameter int CAPACITY     = 256,
   parameter int IW           = 8,
   parameter int LW           = 9,
   parameter int SW           = 32,
   parameter int EW           = 57
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request side
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire ghac_pkg::ghac_req_type req_payload,
   // Result toward the output register
   input  wire logic                  out_free,
   output logic                       res_valid,
   output ghac_pkg::ghac_rsp_type     res,
   // Slot memory
   output logic                       mem_wr_en,
   output logic [IW-1:0]              mem_wr_addr,
   output logic [EW-1:0]              mem_wr_data,
   output logic                       mem_rd_en,
   output logic [IW-1:0]              mem_rd_addr,
   input  wire logic [EW-1:0]         mem_rd_data
);

   import ghac_pkg::*;

   localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
   localparam logic [LW-1:0] NO_SLOT  = LW'(CAPACITY);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_EXEC  = 4'b0100,
      ST_SCAN  = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [IW-1:0]           slot_ff, slot_in;
   logic [LW-1:0]           avail_head_ff, avail_head_in;
   logic [COMMAND_BITS-1:0] cmd_ff, cmd_in;
   logic [GEN_BITS-1:0]     gen_ff, gen_in;
   logic [SW-1:0]           pay_ff, pay_in;
   logic                    hok_ff, hok_in;

   logic [LOW_BITS-1:0]     req_low;
   logic [SW-1:0]           req_pay;
   logic [IW-1:0]           req_slot;
   logic [SW-1:0]           rd_pay;
   logic [GEN_BITS-1:0]     rd_gen;
   logic [GEN_BITS-1:0]     gen_inc;
   logic [LW-1:0]           rd_link;
   logic [LW-1:0]           slot_link;
   logic [LW-1:0]           clr_link;
   logic [LOW_BITS-1:0]     slot_low;
   logic                    hit;
   logic                    scan_match;
   logic                    free_done;

   // Request decode: the slot that the request reads first.
   assign req_low = req_payload.handle_in[LOW_BITS-1:0];
   assign req_pay = SW'(req_payload.payload_in);
   always_comb begin
      case (req_payload.command)
         CMD_ALLOC: req_slot = IW'(avail_head_ff);
         CMD_FIND:  req_slot = '0;
         default:   req_slot = IW'(req_low - LOW_BITS'(1));
      endcase
   end

   // Fields of the slot that was read.
   assign rd_pay     = mem_rd_data[SW-1:0];
   assign rd_gen     = mem_rd_data[SW+GEN_BITS-1:SW];
   assign rd_link    = mem_rd_data[EW-1:SW+GEN_BITS];
   assign gen_inc    = rd_gen + GEN_BITS'(1);
   assign slot_link  = LW'(slot_ff);
   assign clr_link   = slot_link + LW'(1);
   assign slot_low   = LOW_BITS'(slot_ff) + LOW_BITS'(1);
   assign hit        = hok_ff && (rd_gen == gen_ff);
   assign scan_match = (rd_pay == pay_ff);

   assign req_ready = (state_ff == ST_IDLE);

   // Sequencer and read-modify-write datapath.
   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      avail_head_in = avail_head_ff;
      cmd_in        = cmd_ff;
      gen_in        = gen_ff;
      pay_in        = pay_ff;
      hok_in        = hok_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = slot_ff;
      mem_wr_data   = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = slot_ff;
      res_valid     = 1'b0;
      res           = '0;
      free_done     = 1'b0;

      case (state_ff)
         // Initialize every slot: no payload, generation zero, free list in order.
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = {clr_link, {GEN_BITS{1'b0}}, {SW{1'b0}}};
            if (slot_ff == LAST_IDX) begin
               slot_in  = '0;
               state_in = ST_IDLE;
            end else begin
               slot_in = slot_ff + IW'(1);
            end
         end

         // Take a request and read its slot.
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in      = req_payload.command;
               gen_in      = req_payload.handle_in[HANDLE_BITS-1:LOW_BITS];
               pay_in      = req_pay;
               hok_in      = (req_low != '0) && (32'(req_low) <= 32'(CAPACITY));
               slot_in     = req_slot;
               mem_rd_en   = 1'b1;
               mem_rd_addr = req_slot;
               if ((req_payload.command == CMD_FIND) && (req_pay != '0)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end

         // Check the slot, write it back for alloc and free, and hand over the result.
         ST_EXEC: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
               case (cmd_ff)
                  CMD_ALLOC: begin
                     if (avail_head_ff != NO_SLOT) begin
                        mem_wr_en      = 1'b1;
                        mem_wr_data    = {rd_link, rd_gen, pay_ff};
                        avail_head_in  = rd_link;
                        res.handle_out = {rd_gen, slot_low};
                        res.success    = 1'b1;
                     end
                  end
                  CMD_GET: begin
                     if (hit) begin
                        res.payload_out = PORT_PAYLOAD_BITS'(rd_pay);
                        res.success     = 1'b1;
                     end
                  end
                  CMD_FREE: begin
                     if (hit) begin
                        mem_wr_en     = 1'b1;
                        mem_wr_data   = {avail_head_ff, gen_inc, {SW{1'b0}}};
                        avail_head_in = slot_link;
                        res.success   = 1'b1;
                        free_done     = 1'b1;
                     end
                  end
                  CMD_VALID: begin
                     res.success = hit && (rd_pay != '0);
                  end
                  default: begin
                     res = '0;
                  end
               endcase
            end
         end

         // Find: compare one slot per cycle while the next read is in flight.
         ST_SCAN: begin
            if (scan_match || (slot_ff == LAST_IDX)) begin
               if (out_free) begin
                  res_valid = 1'b1;
                  state_in  = ST_IDLE;
                  if (scan_match) begin
                     res.handle_out = {rd_gen, slot_low};
                     res.success    = 1'b1;
                  end
               end
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = slot_ff + IW'(1);
               slot_in     = slot_ff + IW'(1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         slot_ff       <= '0;
         avail_head_ff <= '0;
      end else begin
         state_ff      <= state_in;
         slot_ff       <= slot_in;
         avail_head_ff <= avail_head_in;
      end
   end

   // Request fields held while the request is worked on.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      gen_ff <= gen_in;
      pay_ff <= pay_in;
      hok_ff <= hok_in;
   end

   // The free-list head never points past the end marker.
   `GHAC_ASSERT_ALWAYS(a_head_range, clock, reset, avail_head_ff <= NO_SLOT,
      "free list head out of range")
   // A read and a write of the slot memory never share a cycle.
   `GHAC_ASSERT_ALWAYS(a_mem_onehot, clock, reset, $onehot0({mem_rd_en, mem_wr_en}),
      "slot memory read and write in the same cycle")
   // A successful free makes the freed slot the new list head.
   `GHAC_ASSERT_NEXT(a_free_push, clock, reset, free_done,
      avail_head_ff == $past(slot_link), "freed slot not pushed on the free list")
   // A request is taken only when the engine is idle and no write is pending.
   `GHAC_ASSERT_IMPLY(a_accept_idle, clock, reset, req_valid && req_ready,
      !mem_wr_en && !res_valid, "request taken while a slot update is pending")

endmodule

`default_nettype wire

FILE: hw/rtl/generational_handle_allocator_core.sv
// ----------------------------------------------------------------------------
// Generational handle allocator core
// Alloc, get, free and is-valid read the slot, then check it, write it back
//   where needed and load the output register; a new request is taken
//   only after the previous response has loaded the output register.
// Find reads one slot per cycle until a match or the last slot.
// After reset every slot is initialized in turn; no request is taken until then.
// ----------------------------------------------------------------------------
`default_nettype none

`include "generational_handle_allocator_core_assert.svh"

module generational_handle_allocator_core #(
   parameter int CAPACITY     = 256,
   parameter int PAYLOAD_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire ghac_pkg::ghac_req_type req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output ghac_pkg::ghac_rsp_type     rsp_payload
);

   import ghac_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int SW = (PAYLOAD_BITS < PORT_PAYLOAD_BITS) ? PAYLOAD_BITS
                                                           : PORT_PAYLOAD_BITS;
   localparam int EW = LW + GEN_BITS + SW;

   logic          mem_wr_en;
   logic [IW-1:0] mem_wr_addr;
   logic [EW-1:0] mem_wr_data;
   logic          mem_rd_en;
   logic [IW-1:0] mem_rd_addr;
   logic [EW-1:0] mem_rd_data;

   logic          out_free;
   logic          res_valid;
   ghac_rsp_type  res;

   ghac_rsp_type  rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   ghac_engine #(
      .CAPACITY     (CAPACITY),
      .IW           (IW),
      .LW           (LW),
      .SW           (SW),
      .EW           (EW)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   ghac_slot_mem #(
      .DEPTH (CAPACITY),
      .AW    (IW),
      .WIDTH (EW)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Output register: a new response may load when the slot is empty or draining.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The engine never overwrites a response that is still waiting.
   `GHAC_ASSERT_IMPLY(a_no_overwrite, clock, reset, res_valid,
      !rsp_valid_ff || rsp_ready, "response overwritten before it was taken")

endmodule

`default_nettype wire
